/* hdl/utd_pkg.sv */
package utd_pkg;

    // String length limit for the byte and character counters
    localparam int MAX_STRING_BYTES = 65536;
    localparam int CNT_W = 17;
    localparam int BUF_DEPTH = 6;

    // Decode status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_ILLEGAL = 3'd1;
    localparam logic [2:0] STAT_SHORT   = 3'd2;
    localparam logic [2:0] STAT_UNSUP   = 3'd3;
    localparam logic [2:0] STAT_NEWLINE = 3'd4;
    localparam logic [2:0] STAT_CONTROL = 3'd5;

    // Configuration register indexes
    localparam logic REG_TARGET_MODE = 1'b0;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [30:0]      code_point;
        logic             is_char;
        logic             is_summary;
        logic [2:0]       status;
        logic [CNT_W-1:0] bytes_used;
        logic [CNT_W-1:0] char_count;
        logic             run_last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic append;
        logic step;
        logic short_end;
        logic push_hold;
        logic push_summary;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic short_seq;
        logic char_ok;
        logic hold_valid;
        logic out_free;
        logic fin;
    } stat_t;

endpackage

/* hdl/utd_ctrl.sv */
module utd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  utd_pkg::stat_t st,
    output utd_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    // Sequence the decode steps of one item
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.append = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (st.empty || st.short_seq) begin
                    cmd.short_end = st.short_seq && !st.empty && st.fin;
                    state_next    = S_DONE;
                end else if (!(st.char_ok && st.hold_valid && !st.out_free)) begin
                    cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (st.hold_valid) begin
                    if (st.out_free) begin
                        cmd.push_hold = 1'b1;
                        if (!st.fin) begin
                            state_next = S_IDLE;
                        end
                    end
                end else if (st.fin) begin
                    if (st.out_free) begin
                        cmd.push_summary = 1'b1;
                        state_next       = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/utd_datapath.sv */
module utd_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                target_mode,
    input  utd_pkg::in_item_t   s_data,
    input  utd_pkg::cmd_t       cmd,
    output utd_pkg::stat_t      st,
    output logic                m_valid,
    input  logic                m_ready,
    output utd_pkg::out_item_t  m_data
);

    localparam int CW = utd_pkg::CNT_W;
    localparam logic [CW:0] MAX_CNT = (CW+1)'(utd_pkg::MAX_STRING_BYTES);

    logic [7:0]    buf_reg [utd_pkg::BUF_DEPTH];
    logic [7:0]    buf_next [utd_pkg::BUF_DEPTH];
    logic [2:0]    count_reg, count_next;
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] dec_reg, dec_next;
    logic [2:0]    last_reg, last_next;
    logic          fin_reg, fin_next;
    logic          hold_valid_reg, hold_valid_next;
    logic [30:0]   hold_cp_reg, hold_cp_next;
    logic          out_valid_reg, out_valid_next;
    utd_pkg::out_item_t out_reg, out_next;

    logic [2:0]  seq_n;
    logic [2:0]  jstat;
    logic [2:0]  used;
    logic [30:0] jcp;
    logic        cont_ok;
    logic [7:0]  minb1;
    logic        out_free;
    logic [CW:0] head_sum;
    logic [CW:0] dec_sum;

    // Judge the sequence at the head of the buffer
    always_comb begin
        logic [7:0] c;
        c = buf_reg[0];
        if (c < 8'hc2)       seq_n = 3'd1;
        else if (c < 8'he0)  seq_n = 3'd2;
        else if (c < 8'hf0)  seq_n = 3'd3;
        else if (target_mode) seq_n = 3'd1;
        else if (c < 8'hf8)  seq_n = 3'd4;
        else if (c < 8'hfc)  seq_n = 3'd5;
        else if (c < 8'hfe)  seq_n = 3'd6;
        else                 seq_n = 3'd1;

        cont_ok = 1'b1;
        for (int k = 1; k < utd_pkg::BUF_DEPTH; k++) begin
            if (k < int'(seq_n) && buf_reg[k][7:6] != 2'b10) cont_ok = 1'b0;
        end

        case (c)
            8'he0:   minb1 = 8'ha0;
            8'hf0:   minb1 = 8'h90;
            8'hf8:   minb1 = 8'h88;
            8'hfc:   minb1 = 8'h84;
            default: minb1 = 8'h80;
        endcase

        case (seq_n)
            3'd2:    jcp = {20'd0, c[4:0], buf_reg[1][5:0]};
            3'd3:    jcp = {15'd0, c[3:0], buf_reg[1][5:0], buf_reg[2][5:0]};
            3'd4:    jcp = {10'd0, c[2:0], buf_reg[1][5:0], buf_reg[2][5:0],
                            buf_reg[3][5:0]};
            3'd5:    jcp = {5'd0, c[1:0], buf_reg[1][5:0], buf_reg[2][5:0],
                            buf_reg[3][5:0], buf_reg[4][5:0]};
            3'd6:    jcp = {c[0], buf_reg[1][5:0], buf_reg[2][5:0], buf_reg[3][5:0],
                            buf_reg[4][5:0], buf_reg[5][5:0]};
            default: jcp = {24'd0, c[6:0]};
        endcase

        if (target_mode && c < 8'h20) begin
            jstat = (c == 8'h0a) ? utd_pkg::STAT_NEWLINE : utd_pkg::STAT_CONTROL;
        end else if (c < 8'h80) begin
            jstat = utd_pkg::STAT_OK;
        end else if (c < 8'hc2) begin
            jstat = utd_pkg::STAT_ILLEGAL;
        end else if (seq_n == 3'd1) begin
            jstat = utd_pkg::STAT_UNSUP;
        end else if (!cont_ok || buf_reg[1] < minb1) begin
            jstat = utd_pkg::STAT_ILLEGAL;
        end else begin
            jstat = utd_pkg::STAT_OK;
        end

        used = (jstat == utd_pkg::STAT_OK) ? seq_n : 3'd1;
    end

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        st.empty      = (count_reg == 3'd0);
        st.short_seq  = (seq_n > count_reg);
        st.char_ok    = (jstat == utd_pkg::STAT_OK);
        st.hold_valid = hold_valid_reg;
        st.out_free   = out_free;
        st.fin        = fin_reg;
    end

    // Saturating counter sums
    always_comb begin
        logic [2:0] inc;
        inc      = cmd.short_end ? 3'd1 : used;
        head_sum = {1'b0, head_reg} + {{(CW-2){1'b0}}, inc};
        dec_sum  = {1'b0, dec_reg} + {{CW{1'b0}}, 1'b1};
        if (head_sum > MAX_CNT) head_sum = MAX_CNT;
        if (dec_sum > MAX_CNT) dec_sum = MAX_CNT;
    end

    // Update buffer, counters, held character and output register
    always_comb begin
        for (int i = 0; i < utd_pkg::BUF_DEPTH; i++) buf_next[i] = buf_reg[i];
        count_next      = count_reg;
        head_next       = head_reg;
        dec_next        = dec_reg;
        last_next       = last_reg;
        fin_next        = fin_reg;
        hold_valid_next = hold_valid_reg;
        hold_cp_next    = hold_cp_reg;
        out_next        = out_reg;
        out_valid_next  = m_ready ? 1'b0 : out_valid_reg;

        if (cmd.append) begin
            for (int i = 0; i < utd_pkg::BUF_DEPTH; i++) begin
                if (3'(i) == count_reg) buf_next[i] = s_data.byte_in;
            end
            count_next = count_reg + 3'd1;
            fin_next   = s_data.final_byte;
        end

        if (cmd.step) begin
            // drop the consumed bytes from the head
            for (int i = 0; i < utd_pkg::BUF_DEPTH; i++) begin
                for (int j = 1; j <= utd_pkg::BUF_DEPTH; j++) begin
                    if (3'(j) == used && i + j < utd_pkg::BUF_DEPTH) begin
                        buf_next[i] = buf_reg[i + j];
                    end
                end
            end
            count_next = count_reg - used;
            head_next  = head_sum[CW-1:0];
            last_next  = jstat;
            if (jstat == utd_pkg::STAT_OK) begin
                dec_next        = dec_sum[CW-1:0];
                hold_valid_next = 1'b1;
                hold_cp_next    = jcp;
                if (hold_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.code_point = hold_cp_reg;
                    out_next.is_char    = 1'b1;
                    out_next.status     = utd_pkg::STAT_OK;
                end
            end
        end

        if (cmd.short_end) begin
            last_next  = utd_pkg::STAT_SHORT;
            head_next  = head_sum[CW-1:0];
            count_next = 3'd0;
        end

        if (cmd.push_hold) begin
            hold_valid_next     = 1'b0;
            out_valid_next      = 1'b1;
            out_next            = '0;
            out_next.code_point = hold_cp_reg;
            out_next.is_char    = 1'b1;
            out_next.status     = utd_pkg::STAT_OK;
            out_next.run_last   = !fin_reg;
        end

        if (cmd.push_summary) begin
            out_valid_next      = 1'b1;
            out_next            = '0;
            out_next.is_summary = 1'b1;
            out_next.status     = last_reg;
            out_next.bytes_used = head_reg;
            out_next.char_count = dec_reg;
            out_next.run_last   = 1'b1;
            count_next          = 3'd0;
            head_next           = '0;
            dec_next            = '0;
            last_next           = utd_pkg::STAT_UNSUP;
            fin_next            = 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        for (int i = 0; i < utd_pkg::BUF_DEPTH; i++) buf_reg[i] <= buf_next[i];
        hold_cp_reg <= hold_cp_next;
        out_reg     <= out_next;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= 3'd0;
            head_reg       <= '0;
            dec_reg        <= '0;
            last_reg       <= utd_pkg::STAT_UNSUP;
            fin_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg      <= count_next;
            head_reg       <= head_next;
            dec_reg        <= dec_next;
            last_reg       <= last_next;
            fin_reg        <= fin_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* hdl/utf8_to_code_point_decoder_top.sv */
// UTF-8 decoder: bytes of a string enter one item at a time with final_byte on the
// last one; each decoded character leaves as its own item, and the final byte adds a
// summary item with bytes used, character count and last status. A new byte is taken
// only while the decoder is idle; it then runs decode steps over the buffered bytes
// (one step per character or dropped lead, at most six), finds the buffer exhausted
// and releases the held last character. On the final byte the summary follows the
// release when a character was held, and goes out in place of the release otherwise.
// Stalls on the result channel hold back the steps and the release. The sequencer
// walks the six-byte buffer one step per clock while the result channel does not
// stall. Register target_mode (byte address 0) selects UCS-2 decoding.
module utf8_to_code_point_decoder_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  utd_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output utd_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic           mode_reg;
    utd_pkg::cmd_t  cmd;
    utd_pkg::stat_t st;

    // Configuration register write and read back
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == utd_pkg::REG_TARGET_MODE) begin
            mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == utd_pkg::REG_TARGET_MODE) ? {31'd0, mode_reg} : 32'd0;

    utd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    utd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .target_mode (mode_reg),
        .s_data      (s_data),
        .cmd         (cmd),
        .st          (st),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // Input is taken only with no character held back
    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !st.hold_valid)
        else $error("input ready while a character is held");

    // A summary always ends the run of its item
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_summary |-> m_data.run_last)
        else $error("summary without run_last");

    // Each result is either a character or a summary
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_char != m_data.is_summary))
        else $error("result kind malformed");

    // An accepted item is decoded before the next one is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

endmodule

/* bench/utd_decode_checker.sv */
module utd_decode_checker
    import utd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_item_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_item_t  m_data,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    input  logic       pready,
    output int         mismatches,
    output int         results_due
);

    localparam logic [2:0] MODE_ADDR = 3'(4 * REG_TARGET_MODE);

    // Decoder image: mode bit, byte buffer and per-string counters
    logic        ucs2 = 1'b0;
    logic [7:0]  held [BUF_DEPTH];
    int unsigned held_cnt = 0;
    int unsigned bytes_seen = 0;
    int unsigned chars_seen = 0;
    logic [2:0]  last_st = STAT_UNSUP;
    out_item_t   chars_due_q[$];
    int          err_cnt = 0;

    function automatic int unsigned sat_add(int unsigned a, int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > MAX_STRING_BYTES) ? MAX_STRING_BYTES : s;
    endfunction

    // Length of the sequence that a lead byte announces under the current mode
    function automatic int unsigned seq_len(logic [7:0] c);
        if (c < 8'hc2) return 1;
        if (c < 8'he0) return 2;
        if (c < 8'hf0) return 3;
        if (ucs2) return 1;
        if (c < 8'hf8) return 4;
        if (c < 8'hfc) return 5;
        if (c < 8'hfe) return 6;
        return 1;
    endfunction

    function automatic void clear_string();
        held_cnt   = 0;
        bytes_seen = 0;
        chars_seen = 0;
        last_st    = STAT_UNSUP;
    endfunction

    // Append one byte, decode what the buffer allows, queue the resulting items
    function automatic void decode_byte(logic [7:0] b, logic fin);
        out_item_t   res[$];
        out_item_t   r;
        int unsigned n;
        int unsigned used;
        int unsigned k;
        logic [7:0]  c;
        logic [7:0]  minb1;
        logic [31:0] v;
        logic [30:0] cp;
        logic [2:0]  st;
        logic        done;

        if (held_cnt < BUF_DEPTH) begin
            held[held_cnt] = b;
            held_cnt++;
        end
        done = 1'b0;
        while (held_cnt > 0 && res.size() < BUF_DEPTH && !done) begin
            c = held[0];
            n = seq_len(c);
            if (n > held_cnt) begin
                // Head incomplete: wait, or at the end count the lead and drop the rest
                if (fin) begin
                    last_st    = STAT_SHORT;
                    bytes_seen = sat_add(bytes_seen, 1);
                    held_cnt   = 0;
                end
                done = 1'b1;
            end else begin
                used = 1;
                cp   = '0;
                if (ucs2 && c < 8'h20) begin
                    st = (c == 8'h0a) ? STAT_NEWLINE : STAT_CONTROL;
                end else if (c < 8'h80) begin
                    st = STAT_OK;
                    cp = 31'(c);
                end else if (c < 8'hc2) begin
                    st = STAT_ILLEGAL;
                end else if (n == 1) begin
                    st = STAT_UNSUP;
                end else begin
                    st = STAT_OK;
                    for (k = 1; k < n; k++)
                        if (held[k][7:6] != 2'b10) st = STAT_ILLEGAL;
                    // Overlong forms show up as a low second byte
                    case (c)
                        8'he0:   minb1 = 8'ha0;
                        8'hf0:   minb1 = 8'h90;
                        8'hf8:   minb1 = 8'h88;
                        8'hfc:   minb1 = 8'h84;
                        default: minb1 = 8'h80;
                    endcase
                    if (st == STAT_OK && held[1] < minb1) st = STAT_ILLEGAL;
                    if (st == STAT_OK) begin
                        v = 32'(c) & (32'h7f >> n);
                        for (k = 1; k < n; k++)
                            v = (v << 6) | 32'(held[k][5:0]);
                        cp   = v[30:0];
                        used = n;
                    end
                end
                last_st = st;
                for (k = 0; k + used < BUF_DEPTH; k++)
                    held[k] = held[k + used];
                held_cnt   -= used;
                bytes_seen = sat_add(bytes_seen, used);
                if (st == STAT_OK) begin
                    chars_seen   = sat_add(chars_seen, 1);
                    r            = '0;
                    r.code_point = cp;
                    r.is_char    = 1'b1;
                    r.status     = STAT_OK;
                    res.push_back(r);
                end
            end
        end

        // Summary item closes the string
        if (fin) begin
            r            = '0;
            r.is_summary = 1'b1;
            r.status     = last_st;
            r.bytes_used = bytes_seen[CNT_W-1:0];
            r.char_count = chars_seen[CNT_W-1:0];
            res.push_back(r);
            clear_string();
        end
        if (res.size() > 0) res[res.size() - 1].run_last = 1'b1;
        foreach (res[i]) chars_due_q.push_back(res[i]);
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Compare one result item against the oldest expectation
    task automatic check_result(input out_item_t got);
        out_item_t w;
        if (chars_due_q.size() == 0) begin
            $error("result item with nothing expected: %h", got);
            err_cnt++;
        end else begin
            w = chars_due_q.pop_front();
            check_field("code_point", 64'(w.code_point), 64'(got.code_point));
            check_field("is_char",    64'(w.is_char),    64'(got.is_char));
            check_field("is_summary", 64'(w.is_summary), 64'(got.is_summary));
            check_field("status",     64'(w.status),     64'(got.status));
            check_field("bytes_used", 64'(w.bytes_used), 64'(got.bytes_used));
            check_field("char_count", 64'(w.char_count), 64'(got.char_count));
            check_field("run_last",   64'(w.run_last),   64'(got.run_last));
        end
    endtask

    // Watch both channels and the register port at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            ucs2 = 1'b0;
            clear_string();
            chars_due_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
                ucs2 = pwdata[0];
            if (m_valid && m_ready) check_result(m_data);
            if (s_valid && s_ready) decode_byte(s_data.byte_in, s_data.final_byte);
        end
        mismatches  <= err_cnt;
        results_due <= chars_due_q.size();
    end

endmodule

/* bench/tb_top.sv */
module tb_top;
    import utd_pkg::*;

    localparam logic [2:0] MODE_ADDR = 3'(4 * REG_TARGET_MODE);
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          results_due;
    logic        calm = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    logic        cur_mode = 1'b0;
    logic [7:0]  str_q[$];

    always #10 aclk = ~aclk;

    utf8_to_code_point_decoder_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    utd_decode_checker decode_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                stall = calm ? 0 : pick_gap();
                if (stall == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (stall - 1) @(posedge aclk);
                end
            end
        end
    end

    // Offer one byte after a random gap and hold it until taken
    task automatic send_item(input logic [7:0] b, input logic fin);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_data.byte_in    <= b;
        s_data.final_byte <= fin;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_str();
        for (int i = 0; i < str_q.size(); i++)
            send_item(str_q[i], i == str_q.size() - 1);
    endtask

    // Drop valid, wait for every expected item, then let the block settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        logic [31:0] wdata;
        wdata    = $urandom();
        wdata[0] = m;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_mode = m;
    endtask

    // Lead of an n byte form followed by ncont continuation bytes
    task automatic add_seq(input int n, input int ncont);
        logic [7:0] lead;
        case (n)
            1:       lead = 8'($urandom_range(8'h00, 8'h7f));
            2:       lead = 8'($urandom_range(8'hc2, 8'hdf));
            3:       lead = 8'($urandom_range(8'he0, 8'hef));
            4:       lead = 8'($urandom_range(8'hf0, 8'hf7));
            5:       lead = 8'($urandom_range(8'hf8, 8'hfb));
            default: lead = 8'($urandom_range(8'hfc, 8'hfd));
        endcase
        str_q.push_back(lead);
        for (int k = 0; k < ncont; k++)
            str_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    // Mostly well-formed characters, some noise, some broken sequences
    task automatic add_chunk();
        int r;
        int n;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            if (cur_mode)
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
            else
                n = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 6);
            add_seq(n, n - 1);
        end else if (r < 85) begin
            str_q.push_back(8'($urandom()));
        end else begin
            n = $urandom_range(2, 6);
            add_seq(n, $urandom_range(0, n - 2));
            if ($urandom_range(0, 1) == 1) begin
                b = 8'($urandom());
                if (b[7:6] == 2'b10) b[6] = 1'b1;
                str_q.push_back(b);
            end
        end
    endtask

    task automatic run_phase(input logic m, input int budget);
        int sent;
        wait_drained();
        write_mode(m);
        sent = 0;
        while (sent < budget) begin
            str_q.delete();
            repeat ($urandom_range(1, 6)) add_chunk();
            send_str();
            sent += str_q.size();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        write_mode(1'b0);

        // UCS-4: smallest and largest forms, overlong, bad lead, bad continuation,
        // unsupported lead, and a sequence cut short by the end of the string
        str_q = '{8'h00, 8'h7f, 8'hc2, 8'h80, 8'hf0, 8'h90, 8'h80, 8'h80,
                  8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'he0, 8'h9f, 8'h80,
                  8'hfe, 8'hc3, 8'h41, 8'he2, 8'h82};
        send_str();

        // UCS-2: newline, other control, four byte lead, three byte character
        wait_drained();
        write_mode(1'b1);
        str_q = '{8'h0a, 8'h01, 8'hf0, 8'he2, 8'h82, 8'hac, 8'h7f};
        send_str();

        // Switch modes while a lead waits in the buffer
        wait_drained();
        write_mode(1'b0);
        send_item(8'hf0, 1'b0);
        send_item(8'h90, 1'b0);
        wait_drained();
        write_mode(1'b1);
        send_item(8'h41, 1'b1);

        // Random strings; the first phase starts under a long result hold-off
        wait_drained();
        hold_req = 1'b1;
        run_phase(1'b0, 25);
        run_phase(1'b1, 25);
        calm = 1'b1;
        run_phase(1'b0, 20);
        calm = 1'b0;
        run_phase(1'b1, 20);

        wait_drained();
        if (mismatches == 0 && results_due == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Run limit
    initial begin
        #40000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* utf8_to_code_point_decoder_top.f */
hdl/utd_pkg.sv
hdl/utd_ctrl.sv
hdl/utd_datapath.sv
hdl/utf8_to_code_point_decoder_top.sv
bench/utd_decode_checker.sv
bench/tb_top.sv
